// File: rtl/hsti_pkg.sv
// Package for the handheld system timer / IRQ register block.
// Holds widths, register offsets, the request opcodes and the write-port struct.
// No dependencies.
package hsti_pkg;

  // Field and port widths
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned TIMER_W     = 23;
  localparam int unsigned ADDR_SPAN   = 64;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  // Default register file size
  localparam int unsigned REG_COUNT_DEF = 64;

  // Register offsets
  localparam logic [ADDR_W-1:0] OFS_BUTTONS   = 6'h20;
  localparam logic [ADDR_W-1:0] OFS_LINK      = 6'h21;
  localparam logic [ADDR_W-1:0] OFS_LINKSRC   = 6'h22;
  localparam logic [ADDR_W-1:0] OFS_TIMER     = 6'h23;
  localparam logic [ADDR_W-1:0] OFS_ACK_TIMER = 6'h24;
  localparam logic [ADDR_W-1:0] OFS_ACK_DMA   = 6'h25;
  localparam logic [ADDR_W-1:0] OFS_BANK      = 6'h26;
  localparam logic [ADDR_W-1:0] OFS_STATUS    = 6'h27;

  // Timer reload: value 0 counts as 256
  localparam logic [DATA_W:0] TIMER_VAL_ZERO = 9'h100;

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_READ     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_TICK     = 3'd2,
    OP_DMA_DONE = 3'd3,
    OP_FRAME    = 3'd4
  } op_t;

  // Register file write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

endpackage

// File: rtl/hsti_regfile.sv
// Byte-wide register file with per-entry valid bits (unwritten entries read 0).
// One write port, one registered read port with write-to-read bypass.
// Depends on hsti_pkg.
module hsti_regfile #(
  parameter int unsigned DEPTH = hsti_pkg::REG_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hsti_pkg::wr_req_t            wr,
  input  logic                         rd_en,
  input  logic [hsti_pkg::ADDR_W-1:0]  rd_addr,
  output logic [hsti_pkg::DATA_W-1:0]  rd_data_r
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMP_W = hsti_pkg::ADDR_W + 1;

  logic [hsti_pkg::DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid_r;
  logic [IDX_W-1:0]            widx;
  logic [IDX_W-1:0]            ridx;
  logic                        wr_hit;
  logic                        rd_hit;
  logic                        bypass;

  assign widx   = wr.addr[IDX_W-1:0];
  assign ridx   = rd_addr[IDX_W-1:0];
  assign wr_hit = {1'b0, wr.addr} < CMP_W'(DEPTH);
  assign rd_hit = {1'b0, rd_addr} < CMP_W'(DEPTH);
  // write in the same cycle as a read of the same entry wins
  assign bypass = wr.en && wr_hit && (wr.addr == rd_addr);

  // storage
  always_ff @(posedge clk) begin
    if (wr.en && wr_hit) begin
      mem[widx] <= wr.data;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en && wr_hit) begin
      valid_r[widx] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (bypass) begin
        rd_data_r <= wr.data;
      end else if (rd_hit && valid_r[ridx]) begin
        rd_data_r <= mem[ridx];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

endmodule

// File: rtl/handheld_system_timer_irq_regs.sv
// System register block: 64-byte register file, one-shot timer, IRQ/NMI and ROM bank.
// Takes one request per cycle while out_tready is high (read, write, tick, DMA done,
// frame) and returns one result per request through the input register, the register
// file read port and the result register; a stalled output holds the flow. An output
// register decouples the sides, so a new request is taken while a result waits.
// Depends on hsti_pkg and hsti_regfile.
module handheld_system_timer_irq_regs #(
  parameter int unsigned REG_COUNT = hsti_pkg::REG_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [5:0] reg_address, [13:6] write_value, [21:14] buttons, [23:22] zero
  input  logic [hsti_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] opcode
  input  logic [hsti_pkg::OP_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] read_value, [8] irq_line, [9] nmi_pulse, [12:10] rom_bank, [15:13] zero
  output logic [hsti_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int unsigned DEPTH = (REG_COUNT < hsti_pkg::ADDR_SPAN) ?
                                  REG_COUNT : hsti_pkg::ADDR_SPAN;
  localparam int unsigned DW = hsti_pkg::DATA_W;
  localparam int unsigned TW = hsti_pkg::TIMER_W;

  // input stage
  logic                          a_valid_r;
  hsti_pkg::op_t                 a_op_r;
  logic [hsti_pkg::ADDR_W-1:0]   a_addr_r;
  logic [DW-1:0]                 a_wval_r;
  logic [DW-1:0]                 a_btn_r;

  // block state
  logic [DW-1:0] bank_r, bank_nxt;
  logic [DW-1:0] link_src_r, link_src_nxt;
  logic [TW-1:0] tcnt_r, tcnt_nxt;
  logic          trun_r, trun_nxt;
  logic          tshot_r, tshot_nxt;
  logic          dma_r, dma_nxt;

  // output stage
  logic                            out_valid_r;
  logic [hsti_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic              accept;
  logic              advance;
  logic [DW-1:0]     rdata;
  logic [DW-1:0]     rd_val;
  logic              nmi;
  logic              irq;
  logic [DW:0]       tval;
  hsti_pkg::wr_req_t wr_req;

  // handshake
  assign advance   = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r   <= hsti_pkg::op_t'(in_tuser);
      a_addr_r <= in_tdata[5:0];
      a_wval_r <= in_tdata[13:6];
      a_btn_r  <= in_tdata[21:14];
    end
  end

  // register file: read at accept, write when the request completes
  assign wr_req.en   = advance && (a_op_r == hsti_pkg::OP_WRITE);
  assign wr_req.addr = a_addr_r;
  assign wr_req.data = a_wval_r;

  hsti_regfile #(
    .DEPTH (DEPTH)
  ) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr_req),
    .rd_en     (accept),
    .rd_addr   (in_tdata[5:0]),
    .rd_data_r (rdata)
  );

  // request decode and state update
  always_comb begin
    bank_nxt     = bank_r;
    link_src_nxt = link_src_r;
    tcnt_nxt     = tcnt_r;
    trun_nxt     = trun_r;
    tshot_nxt    = tshot_r;
    dma_nxt      = dma_r;
    rd_val       = '0;
    nmi          = 1'b0;
    tval         = (a_wval_r == '0) ? hsti_pkg::TIMER_VAL_ZERO : {1'b0, a_wval_r};
    case (a_op_r)
      hsti_pkg::OP_READ: begin
        case (a_addr_r)
          hsti_pkg::OFS_BUTTONS:   rd_val = a_btn_r;
          hsti_pkg::OFS_LINK:      rd_val = {rdata[7:4], link_src_r[3:0]};
          hsti_pkg::OFS_STATUS:    rd_val = {rdata[7:2], dma_r, tshot_r};
          hsti_pkg::OFS_ACK_TIMER: begin
            rd_val    = rdata;
            tshot_nxt = 1'b0;
          end
          hsti_pkg::OFS_ACK_DMA: begin
            rd_val  = rdata;
            dma_nxt = 1'b0;
          end
          default:                 rd_val = rdata;
        endcase
      end
      hsti_pkg::OP_WRITE: begin
        if (a_addr_r == hsti_pkg::OFS_BANK) begin
          bank_nxt = a_wval_r;
        end
        if (a_addr_r == hsti_pkg::OFS_LINKSRC) begin
          link_src_nxt = a_wval_r;
        end
        if (a_addr_r == hsti_pkg::OFS_TIMER) begin
          // prescaler 16384 or 256 is a shift
          if (bank_r[4]) begin
            tcnt_nxt = {tval, 14'b0};
          end else begin
            tcnt_nxt = TW'({tval, 8'b0});
          end
          trun_nxt = 1'b1;
        end
      end
      hsti_pkg::OP_TICK: begin
        if (trun_r) begin
          tcnt_nxt = tcnt_r - TW'(1);
          if (tcnt_nxt == '0) begin
            tshot_nxt = 1'b1;
            trun_nxt  = 1'b0;
          end
        end
      end
      hsti_pkg::OP_DMA_DONE: dma_nxt = 1'b1;
      hsti_pkg::OP_FRAME:    nmi     = bank_r[0];
      default: ;
    endcase
    irq = (tshot_nxt && bank_nxt[1]) || (dma_nxt && bank_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= '0;
      link_src_r <= '0;
      tcnt_r     <= '0;
      trun_r     <= 1'b0;
      tshot_r    <= 1'b0;
      dma_r      <= 1'b0;
    end else if (advance) begin
      bank_r     <= bank_nxt;
      link_src_r <= link_src_nxt;
      tcnt_r     <= tcnt_nxt;
      trun_r     <= trun_nxt;
      tshot_r    <= tshot_nxt;
      dma_r      <= dma_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {3'b000, bank_nxt[7:5], nmi, irq, rd_val};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
